// File: hw/rtl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

   localparam int MAX_FRAME   = 255;
   localparam int MIN_FRAME   = 6;
   localparam int HDR_LEN     = 4;
   localparam int CRC_BYTES   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] CRC_POLY_RESET = 16'h8408;
   localparam logic [15:0] CRC_INIT       = 16'h0000;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } sfd_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_CRC   = 2'd1,
      STATUS_TOO_SHORT = 2'd2,
      STATUS_TOO_LONG  = 2'd3
   } sfd_status_type;

   typedef struct packed {
      sfd_kind_type   result_kind;
      logic [7:0]     payload_byte;
      sfd_status_type frame_status;
      logic [7:0]     sync_byte;
      logic [7:0]     device_address;
      logic [7:0]     length_field;
      logic [7:0]     command_code;
      logic [7:0]     data_length;
      logic           last_of_run;
   } sfd_result_type;

   // up to two results per byte, entry0 first
   typedef struct packed {
      logic [1:0]     count;
      sfd_result_type entry0;
      sfd_result_type entry1;
   } sfd_push_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0]  b,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sfd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_frame;

   modport source (output valid, output rx_byte, output end_of_frame, input ready);
   modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface sfd_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] payload_byte;
   logic [1:0] frame_status;
   logic [7:0] sync_byte;
   logic [7:0] device_address;
   logic [7:0] length_field;
   logic [7:0] command_code;
   logic [7:0] data_length;
   logic       last_of_run;

   modport source (output valid, output result_kind, output payload_byte,
                   output frame_status, output sync_byte, output device_address,
                   output length_field, output command_code, output data_length,
                   output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input frame_status, input sync_byte, input device_address,
                   input length_field, input command_code, input data_length,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sfd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sfd_req_if.sink                    req_if,
   input  wire logic                  csr_we,
   input  wire logic [15:0]           csr_wdata,
   input  wire logic                  room,
   output sfd_pkg::sfd_push_type      push
);

   logic        a_valid_ff, a_valid_in;
   logic [7:0]  a_rx_ff;
   logic        a_eof_ff;
   logic        advance;

   logic [15:0] poly_ff;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  dly_ff [2];
   logic [7:0]  dly_in [2];
   logic [7:0]  hdr_ff [4];
   logic [7:0]  hdr_in [4];
   logic        ovf_ff, ovf_in;

   logic [15:0]               crc_new;
   logic [7:0]                hdr_upd [4];
   logic                      ovf_upd;
   logic [8:0]                total;
   logic [15:0]               got;
   sfd_pkg::sfd_status_type   status;
   logic                      emit_pay;
   sfd_pkg::sfd_result_type   pay_res, sta_res;

   assign req_if.ready = !a_valid_ff || room;
   assign advance      = a_valid_ff && room;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_if.valid && req_if.ready) begin
         a_valid_in = 1'b1;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (req_if.valid && req_if.ready) begin
         a_rx_ff  <= req_if.rx_byte;
         a_eof_ff <= req_if.end_of_frame;
      end
   end

   always_comb begin
      emit_pay = pos_ff >= 8'(sfd_pkg::HDR_LEN + sfd_pkg::CRC_BYTES);
      crc_new  = (pos_ff >= 8'(sfd_pkg::CRC_BYTES))
                 ? sfd_pkg::crc_byte(crc_ff, dly_ff[0], poly_ff) : crc_ff;
      for (int i = 0; i < 4; i++) begin
         hdr_upd[i] = hdr_ff[i];
      end
      if (pos_ff < 8'(sfd_pkg::HDR_LEN)) begin
         hdr_upd[pos_ff[1:0]] = a_rx_ff;
      end
      ovf_upd = ovf_ff || (pos_ff >= 8'(sfd_pkg::MAX_FRAME));
      total   = {1'b0, pos_ff} + 9'd1;
      got     = {a_rx_ff, dly_ff[1]};

      if (ovf_upd || total > 9'(sfd_pkg::MAX_FRAME)) begin
         status = sfd_pkg::STATUS_TOO_LONG;
      end else if (total < 9'(sfd_pkg::MIN_FRAME)) begin
         status = sfd_pkg::STATUS_TOO_SHORT;
      end else if (crc_new != got) begin
         status = sfd_pkg::STATUS_BAD_CRC;
      end else begin
         status = sfd_pkg::STATUS_OK;
      end

      pay_res              = '0;
      pay_res.result_kind  = sfd_pkg::KIND_PAYLOAD;
      pay_res.payload_byte = dly_ff[0];
      pay_res.last_of_run  = !a_eof_ff;

      sta_res                = '0;
      sta_res.result_kind    = sfd_pkg::KIND_STATUS;
      sta_res.frame_status   = status;
      sta_res.sync_byte      = hdr_upd[0];
      sta_res.device_address = hdr_upd[1];
      sta_res.length_field   = hdr_upd[2];
      sta_res.command_code   = hdr_upd[3];
      sta_res.data_length    = (hdr_upd[2] >= 8'(sfd_pkg::MIN_FRAME))
                               ? hdr_upd[2] - 8'(sfd_pkg::MIN_FRAME) : 8'd0;
      sta_res.last_of_run    = 1'b1;

      push = '0;
      if (advance) begin
         if (emit_pay && a_eof_ff) begin
            push.count  = 2'd2;
            push.entry0 = pay_res;
            push.entry1 = sta_res;
         end else if (emit_pay) begin
            push.count  = 2'd1;
            push.entry0 = pay_res;
         end else if (a_eof_ff) begin
            push.count  = 2'd1;
            push.entry0 = sta_res;
         end
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      dly_in[0] = dly_ff[0];
      dly_in[1] = dly_ff[1];
      for (int i = 0; i < 4; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      ovf_in = ovf_ff;
      if (advance) begin
         if (a_eof_ff) begin
            pos_in    = '0;
            crc_in    = sfd_pkg::CRC_INIT;
            dly_in[0] = '0;
            dly_in[1] = '0;
            for (int i = 0; i < 4; i++) begin
               hdr_in[i] = '0;
            end
            ovf_in = 1'b0;
         end else begin
            crc_in    = crc_new;
            dly_in[0] = dly_ff[1];
            dly_in[1] = a_rx_ff;
            for (int i = 0; i < 4; i++) begin
               hdr_in[i] = hdr_upd[i];
            end
            ovf_in = ovf_upd;
            if (pos_ff != 8'hFF) begin
               pos_in = pos_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff   <= sfd_pkg::CRC_POLY_RESET;
         pos_ff    <= '0;
         crc_ff    <= sfd_pkg::CRC_INIT;
         dly_ff[0] <= '0;
         dly_ff[1] <= '0;
         for (int i = 0; i < 4; i++) begin
            hdr_ff[i] <= '0;
         end
         ovf_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            poly_ff <= csr_wdata;
         end
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         dly_ff[0] <= dly_in[0];
         dly_ff[1] <= dly_in[1];
         for (int i = 0; i < 4; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
         ovf_ff <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/sfd_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sfd_pkg::sfd_push_type push,
   output logic                       room,
   sfd_rsp_if.source                  rsp_if
);

   sfd_pkg::sfd_result_type          q_ff [sfd_pkg::QUEUE_DEPTH];
   logic [sfd_pkg::PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [sfd_pkg::PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [sfd_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             pop;
   sfd_pkg::sfd_result_type          head;

   // two free entries guarantee space for any item's results
   assign room = cnt_ff <= sfd_pkg::CNT_W'(sfd_pkg::QUEUE_DEPTH - 2);
   assign pop  = rsp_if.valid && rsp_if.ready;
   assign head = q_ff[rd_ptr_ff];

   assign rsp_if.valid          = cnt_ff != '0;
   assign rsp_if.result_kind    = head.result_kind;
   assign rsp_if.payload_byte   = head.payload_byte;
   assign rsp_if.frame_status   = head.frame_status;
   assign rsp_if.sync_byte      = head.sync_byte;
   assign rsp_if.device_address = head.device_address;
   assign rsp_if.length_field   = head.length_field;
   assign rsp_if.command_code   = head.command_code;
   assign rsp_if.data_length    = head.data_length;
   assign rsp_if.last_of_run    = head.last_of_run;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sfd_pkg::PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + sfd_pkg::PTR_W'(pop);
      cnt_in    = cnt_ff + sfd_pkg::CNT_W'(push.count) - sfd_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.entry0;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_ptr_ff + sfd_pkg::PTR_W'(1)] <= push.entry1;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/serial_frame_deframer_crc16_unit.sv
// Receive deframer for serial command frames guarded by a reflected CRC-16
// (initial value zero, polynomial in the CSR, 0x8408 after reset). Takes one
// byte per clock while the result queue has room; bytes from position 4
// onward come out as payload items two bytes late, so the trailing CRC pair is
// never forwarded. The byte flagged as end of frame yields a status item (ok,
// bad CRC, short, long) with the four header bytes and the data length, after
// any payload item of that byte. An accepted byte passes an input register and
// the CRC/frame logic, then enters a four-entry result queue: with the queue
// empty, a byte's results are offered once they are written to the queue. The
// input accepts a byte per cycle while the queue has two free entries; a byte
// giving two items occupies the output for two handshakes, which limits the
// sustained rate when the sink keeps up. Write the CSR only while idle.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_deframer_crc16_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   sfd_req_if.sink          req_if,
   sfd_rsp_if.source        rsp_if,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   sfd_pkg::sfd_push_type push;
   logic                  room;

   sfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .room      (room),
      .push      (push)
   );

   sfd_rsp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire
